@@ hdl/two_level_round_robin_scheduler_macros.svh @@
// assertion helpers, clocked on clk and disabled while arst_n is low
`ifndef TWO_LEVEL_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define TWO_LEVEL_ROUND_ROBIN_SCHEDULER_MACROS_SVH

// expression holds at every edge
`define TRR_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TRR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TRR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/trr_pkg.sv @@
`timescale 1ns / 1ps

package trr_pkg;

	localparam int TASK_W   = 16;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;
	localparam int QUANT_W  = 16;
	localparam int UPC_W    = 5;

	localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd10;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK         = 3'd0,
		CMD_ADD          = 3'd1,
		CMD_FINISH       = 3'd2,
		CMD_PROMOTE_HEAD = 3'd3,
		CMD_PROMOTE_ID   = 3'd4,
		CMD_DEMOTE_HEAD  = 3'd5,
		CMD_DEMOTE_ID    = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_NO_FINISH = 3'd4
	} status_t;

	// datapath micro-operations
	typedef enum logic [3:0] {
		U_NOP,
		U_ACCEPT,
		U_TICK,
		U_RD,
		U_RDNEXT,
		U_RDHEAD,
		U_ROT,
		U_APPEND,
		U_POPMV,
		U_LOADMV,
		U_INCPOS,
		U_SHWR,
		U_DROP,
		U_EMIT
	} uop_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_IN,
		C_OUT_BUSY,
		C_SRC_EMPTY,
		C_SRC_LE1,
		C_DST_FULL,
		C_MATCH,
		C_LAST,
		C_NOT_LAST,
		C_NO_ROT
	} cond_t;

	typedef logic [UPC_W-1:0] upc_t;

	typedef struct packed {
		uop_t    uop;
		cond_t   cond;
		upc_t    target;
		logic    dispatch;
		status_t st;
	} uword_t;

	typedef struct packed {
		logic src_empty;
		logic src_le1;
		logic dst_full;
		logic match;
		logic last;
		logic no_rot;
	} dp_flags_t;

	typedef struct packed {
		logic [TASK_W-1:0] running_id;
		logic              running_valid;
		logic              running_is_high;
		status_t           status;
	} result_t;

endpackage

@@ hdl/trr_ifs.sv @@
`timescale 1ns / 1ps

interface trr_cmd_if;
	import trr_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [TASK_W-1:0] task_id;
	modport source (output valid, command, task_id, input ready);
	modport sink (input valid, command, task_id, output ready);
endinterface

interface trr_res_if;
	import trr_pkg::*;
	logic                valid;
	logic                ready;
	logic [TASK_W-1:0]   running_id;
	logic                running_valid;
	logic                running_is_high;
	logic [STATUS_W-1:0] status;
	modport source (output valid, running_id, running_valid, running_is_high, status,
		input ready);
	modport sink (input valid, running_id, running_valid, running_is_high, status,
		output ready);
endinterface

interface trr_cfg_if;
	import trr_pkg::*;
	logic               valid;
	logic               ready;
	logic [QUANT_W-1:0] quantum_ticks;
	modport source (output valid, quantum_ticks, input ready);
	modport sink (input valid, quantum_ticks, output ready);
endinterface

@@ hdl/two_level_round_robin_scheduler.sv @@
`timescale 1ns / 1ps
// two-level round-robin scheduler
// cmd channel: one item per command (tick, add, finish, promote or demote by head or id)
// res channel: one item per command with the running task, its queue and a status code
// cfg channel: writes quantum_ticks, always ready; write it only while no command is in work
// a microcoded sequencer steps a datapath holding two circular task queues in memories
// by-id moves scan the source queue one entry at a time, with one memory read port per queue
// one command is in work at a time; the next is taken once the result is in the output
//   register, so a stalled receiver holds one result and the sequencer waits at the next one
// reset: both queues empty, quantum 10, elapsed count zero; no memory clearing pass
// res holds its item stable until res.ready is seen high
module two_level_round_robin_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 16
) (
	input logic       clk,
	input logic       arst_n,
	trr_cmd_if.sink   cmd,
	trr_res_if.source res,
	trr_cfg_if.sink   cfg
);
	import trr_pkg::*;

	uword_t    uw;
	dp_flags_t flags;
	result_t   result;
	result_t   res_q;
	logic      out_valid_q;
	logic      in_fire;
	logic      out_busy;
	logic      emit;

	assign cmd.ready = uw.uop == U_ACCEPT;
	assign in_fire   = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign out_busy  = out_valid_q && !res.ready;
	assign emit      = (uw.uop == U_EMIT) && !out_busy;

	trr_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.out_busy (out_busy),
		.in_cmd   (cmd_t'(cmd.command)),
		.flags    (flags),
		.uw       (uw)
	);

	trr_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.uw       (uw),
		.in_fire  (in_fire),
		.in_cmd   (cmd_t'(cmd.command)),
		.in_id    (cmd.task_id),
		.cfg_fire (cfg.valid),
		.cfg_data (cfg.quantum_ticks),
		.flags    (flags),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= result;
		end
	end

	assign res.valid           = out_valid_q;
	assign res.running_id      = res_q.running_id;
	assign res.running_valid   = res_q.running_valid;
	assign res.running_is_high = res_q.running_is_high;
	assign res.status          = res_q.status;

endmodule

@@ hdl/trr_seq.sv @@
`timescale 1ns / 1ps

module trr_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               out_busy,
	input  trr_pkg::cmd_t      in_cmd,
	input  trr_pkg::dp_flags_t flags,
	output trr_pkg::uword_t    uw
);
	import trr_pkg::*;

	// microprogram addresses
	localparam upc_t A_TICK     = 5'd0;
	localparam upc_t A_TICK_RD  = 5'd1;
	localparam upc_t A_TICK_ROT = 5'd2;
	localparam upc_t A_ADD      = 5'd3;
	localparam upc_t A_ADD_PUT  = 5'd4;
	localparam upc_t A_FIN      = 5'd5;
	localparam upc_t A_FIN_POP  = 5'd6;
	localparam upc_t A_HMOVE    = 5'd7;
	localparam upc_t A_HM_CHK   = 5'd8;
	localparam upc_t A_HM_POP   = 5'd9;
	localparam upc_t A_HM_PUT   = 5'd10;
	localparam upc_t A_SCAN     = 5'd11;
	localparam upc_t A_SC_RD    = 5'd12;
	localparam upc_t A_SC_CMP   = 5'd13;
	localparam upc_t A_SC_NEXT  = 5'd14;
	localparam upc_t A_S_NF     = 5'd15;
	localparam upc_t A_FOUND    = 5'd16;
	localparam upc_t A_SH_CHK   = 5'd17;
	localparam upc_t A_SH_RD    = 5'd18;
	localparam upc_t A_SH_WR    = 5'd19;
	localparam upc_t A_TAIL     = 5'd20;
	localparam upc_t A_TAIL_PUT = 5'd21;
	localparam upc_t A_S_EMPTY  = 5'd22;
	localparam upc_t A_S_FULL   = 5'd23;
	localparam upc_t A_S_NOFIN  = 5'd24;
	localparam upc_t A_HEADRD   = 5'd25;
	localparam upc_t A_EMIT     = 5'd26;
	localparam upc_t A_IDLE     = 5'd27;

	function automatic uword_t w(uop_t u, cond_t c, upc_t t, status_t s);
		uword_t r;
		r.uop      = u;
		r.cond     = c;
		r.target   = t;
		r.dispatch = 1'b0;
		r.st       = s;
		return r;
	endfunction

	function automatic uword_t ucode(upc_t pc);
		uword_t r;
		r = w(U_NOP, C_ALWAYS, A_IDLE, ST_OK);
		case (pc)
			A_TICK:     r = w(U_TICK, C_NO_ROT, A_HEADRD, ST_OK);
			A_TICK_RD:  r = w(U_RD, C_SRC_LE1, A_HEADRD, ST_OK);
			A_TICK_ROT: r = w(U_ROT, C_ALWAYS, A_HEADRD, ST_OK);
			A_ADD:      r = w(U_NOP, C_DST_FULL, A_S_FULL, ST_OK);
			A_ADD_PUT:  r = w(U_APPEND, C_ALWAYS, A_HEADRD, ST_OK);
			A_FIN:      r = w(U_NOP, C_SRC_EMPTY, A_S_NOFIN, ST_OK);
			A_FIN_POP:  r = w(U_POPMV, C_ALWAYS, A_HEADRD, ST_OK);
			A_HMOVE:    r = w(U_RD, C_SRC_EMPTY, A_S_EMPTY, ST_OK);
			A_HM_CHK:   r = w(U_NOP, C_DST_FULL, A_S_FULL, ST_OK);
			A_HM_POP:   r = w(U_POPMV, C_NEVER, A_IDLE, ST_OK);
			A_HM_PUT:   r = w(U_APPEND, C_ALWAYS, A_HEADRD, ST_OK);
			A_SCAN:     r = w(U_NOP, C_SRC_EMPTY, A_S_NF, ST_OK);
			A_SC_RD:    r = w(U_RD, C_NEVER, A_IDLE, ST_OK);
			A_SC_CMP:   r = w(U_NOP, C_MATCH, A_FOUND, ST_OK);
			A_SC_NEXT:  r = w(U_INCPOS, C_NOT_LAST, A_SC_RD, ST_OK);
			A_S_NF:     r = w(U_NOP, C_ALWAYS, A_HEADRD, ST_NOT_FOUND);
			A_FOUND:    r = w(U_LOADMV, C_DST_FULL, A_S_FULL, ST_OK);
			A_SH_CHK:   r = w(U_NOP, C_LAST, A_TAIL, ST_OK);
			A_SH_RD:    r = w(U_RDNEXT, C_NEVER, A_IDLE, ST_OK);
			A_SH_WR:    r = w(U_SHWR, C_ALWAYS, A_SH_CHK, ST_OK);
			A_TAIL:     r = w(U_DROP, C_NEVER, A_IDLE, ST_OK);
			A_TAIL_PUT: r = w(U_APPEND, C_ALWAYS, A_HEADRD, ST_OK);
			A_S_EMPTY:  r = w(U_NOP, C_ALWAYS, A_HEADRD, ST_EMPTY);
			A_S_FULL:   r = w(U_NOP, C_ALWAYS, A_HEADRD, ST_FULL);
			A_S_NOFIN:  r = w(U_NOP, C_NEVER, A_IDLE, ST_NO_FINISH);
			A_HEADRD:   r = w(U_RDHEAD, C_NEVER, A_IDLE, ST_OK);
			A_EMIT:     r = w(U_EMIT, C_OUT_BUSY, A_EMIT, ST_OK);
			A_IDLE: begin
				r = w(U_ACCEPT, C_NOT_IN, A_IDLE, ST_OK);
				r.dispatch = 1'b1;
			end
			default:    r = w(U_NOP, C_ALWAYS, A_IDLE, ST_OK);
		endcase
		return r;
	endfunction

	function automatic upc_t dispatch(cmd_t c);
		upc_t t;
		case (c)
			CMD_TICK:                         t = A_TICK;
			CMD_ADD:                          t = A_ADD;
			CMD_FINISH:                       t = A_FIN;
			CMD_PROMOTE_HEAD, CMD_DEMOTE_HEAD: t = A_HMOVE;
			CMD_PROMOTE_ID, CMD_DEMOTE_ID:    t = A_SCAN;
			default:                          t = A_HEADRD;
		endcase
		return t;
	endfunction

	upc_t pc_q;
	upc_t pc_next;
	logic take;

	assign uw = ucode(pc_q);

	always_comb begin
		case (uw.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NOT_IN:    take = !in_valid;
			C_OUT_BUSY:  take = out_busy;
			C_SRC_EMPTY: take = flags.src_empty;
			C_SRC_LE1:   take = flags.src_le1;
			C_DST_FULL:  take = flags.dst_full;
			C_MATCH:     take = flags.match;
			C_LAST:      take = flags.last;
			C_NOT_LAST:  take = !flags.last;
			C_NO_ROT:    take = flags.no_rot;
			default:     take = 1'b0;
		endcase
	end

	always_comb begin
		if (take) begin
			pc_next = uw.target;
		end else if (uw.dispatch) begin
			pc_next = dispatch(in_cmd);
		end else begin
			pc_next = pc_q + upc_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

@@ hdl/trr_dp.sv @@
`timescale 1ns / 1ps
`include "two_level_round_robin_scheduler_macros.svh"

module trr_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_WIDTH    = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  trr_pkg::uword_t              uw,
	input  logic                         in_fire,
	input  trr_pkg::cmd_t                in_cmd,
	input  logic [trr_pkg::TASK_W-1:0]   in_id,
	input  logic                         cfg_fire,
	input  logic [trr_pkg::QUANT_W-1:0]  cfg_data,
	output trr_pkg::dp_flags_t           flags,
	output trr_pkg::result_t             result
);
	import trr_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	// circular index: base < depth, off <= depth
	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= SW'(QUEUE_DEPTH)) begin
			s = s - SW'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	logic [ID_WIDTH-1:0] h_mem [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] l_mem [QUEUE_DEPTH];

	logic [AW-1:0]       h_head_q, l_head_q;
	logic [CW-1:0]       h_cnt_q, l_cnt_q;
	logic [QUANT_W-1:0]  elapsed_q, quantum_q;
	logic                s_hi_q;
	logic [CW-1:0]       pos_q;
	logic [ID_WIDTH-1:0] id_q, mv_q, h_rd_q, l_rd_q;
	status_t             status_q;

	logic [AW-1:0]       src_head, dst_head;
	logic [CW-1:0]       src_cnt, dst_cnt;
	logic [ID_WIDTH-1:0] src_rd;
	logic [CW-1:0]       rd_off;
	logic                rd_en;
	logic [AW-1:0]       h_raddr, l_raddr;
	logic                wr_en, wr_hi;
	logic [AW-1:0]       wr_addr;
	logic [ID_WIDTH-1:0] wr_data;
	logic [QUANT_W-1:0]  q_eff, elapsed_inc;
	logic                expire, no_task;

	// source is high for add, demote and a running high task, destination is the other one
	assign src_head = s_hi_q ? h_head_q : l_head_q;
	assign src_cnt  = s_hi_q ? h_cnt_q : l_cnt_q;
	assign dst_head = s_hi_q ? l_head_q : h_head_q;
	assign dst_cnt  = s_hi_q ? l_cnt_q : h_cnt_q;
	assign src_rd   = s_hi_q ? h_rd_q : l_rd_q;

	always_comb begin
		case (uw.uop)
			U_RDNEXT: rd_off = pos_q + CW'(1);
			U_RDHEAD: rd_off = '0;
			default:  rd_off = pos_q;
		endcase
	end

	assign rd_en   = (uw.uop == U_RD) || (uw.uop == U_RDNEXT) || (uw.uop == U_RDHEAD);
	assign h_raddr = wrap(h_head_q, rd_off);
	assign l_raddr = wrap(l_head_q, rd_off);

	always_comb begin
		wr_en   = 1'b0;
		wr_hi   = s_hi_q;
		wr_addr = wrap(src_head, pos_q);
		wr_data = src_rd;
		case (uw.uop)
			U_ROT: begin
				wr_en   = 1'b1;
				wr_addr = wrap(src_head, src_cnt);
			end
			U_SHWR: begin
				wr_en = 1'b1;
			end
			U_APPEND: begin
				wr_en   = 1'b1;
				wr_hi   = !s_hi_q;
				wr_addr = wrap(dst_head, dst_cnt);
				wr_data = mv_q;
			end
			default: ;
		endcase
	end

	// quantum of zero behaves as one, elapsed count saturates
	assign q_eff       = (quantum_q == '0) ? QUANT_W'(1) : quantum_q;
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + QUANT_W'(1);
	assign expire      = elapsed_inc >= q_eff;
	assign no_task     = (h_cnt_q == '0) && (l_cnt_q == '0);

	assign flags.src_empty = src_cnt == '0;
	assign flags.src_le1   = src_cnt <= CW'(1);
	assign flags.dst_full  = dst_cnt == DEPTH_C;
	assign flags.match     = src_rd == id_q;
	assign flags.last      = (SW'(pos_q) + SW'(1)) >= SW'(src_cnt);
	assign flags.no_rot    = no_task || !expire;

	always_comb begin
		if (h_cnt_q != '0) begin
			result.running_id      = TASK_W'(h_rd_q);
			result.running_valid   = 1'b1;
			result.running_is_high = 1'b1;
		end else if (l_cnt_q != '0) begin
			result.running_id      = TASK_W'(l_rd_q);
			result.running_valid   = 1'b1;
			result.running_is_high = 1'b0;
		end else begin
			result.running_id      = '0;
			result.running_valid   = 1'b0;
			result.running_is_high = 1'b0;
		end
		result.status = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_head_q  <= '0;
			l_head_q  <= '0;
			h_cnt_q   <= '0;
			l_cnt_q   <= '0;
			elapsed_q <= '0;
			quantum_q <= QUANTUM_RESET;
			s_hi_q    <= 1'b0;
			pos_q     <= '0;
		end else begin
			if (cfg_fire) begin
				quantum_q <= cfg_data;
			end
			if (in_fire) begin
				pos_q <= '0;
				case (in_cmd)
					CMD_ADD, CMD_DEMOTE_HEAD, CMD_DEMOTE_ID: s_hi_q <= 1'b1;
					CMD_PROMOTE_HEAD, CMD_PROMOTE_ID:        s_hi_q <= 1'b0;
					default:                                 s_hi_q <= h_cnt_q != '0;
				endcase
				// every command but a tick restarts the quantum
				if (in_cmd inside {CMD_ADD, CMD_FINISH, CMD_PROMOTE_HEAD, CMD_PROMOTE_ID,
					CMD_DEMOTE_HEAD, CMD_DEMOTE_ID}) begin
					elapsed_q <= '0;
				end
			end
			case (uw.uop)
				U_TICK: begin
					elapsed_q <= (no_task || expire) ? '0 : elapsed_inc;
				end
				U_ROT: begin
					if (s_hi_q) begin
						h_head_q <= wrap(h_head_q, CW'(1));
					end else begin
						l_head_q <= wrap(l_head_q, CW'(1));
					end
				end
				U_POPMV: begin
					if (s_hi_q) begin
						h_head_q <= wrap(h_head_q, CW'(1));
						h_cnt_q  <= h_cnt_q - CW'(1);
					end else begin
						l_head_q <= wrap(l_head_q, CW'(1));
						l_cnt_q  <= l_cnt_q - CW'(1);
					end
				end
				U_DROP: begin
					if (s_hi_q) begin
						h_cnt_q <= h_cnt_q - CW'(1);
					end else begin
						l_cnt_q <= l_cnt_q - CW'(1);
					end
				end
				U_APPEND: begin
					if (s_hi_q) begin
						l_cnt_q <= l_cnt_q + CW'(1);
					end else begin
						h_cnt_q <= h_cnt_q + CW'(1);
					end
				end
				U_INCPOS, U_SHWR: begin
					pos_q <= pos_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			id_q     <= ID_WIDTH'(in_id);
			mv_q     <= ID_WIDTH'(in_id);
			status_q <= ST_OK;
		end
		if ((uw.uop == U_LOADMV) || (uw.uop == U_POPMV)) begin
			mv_q <= src_rd;
		end
		if (uw.st != ST_OK) begin
			status_q <= uw.st;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_hi) begin
			h_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			h_rd_q <= h_mem[h_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !wr_hi) begin
			l_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			l_rd_q <= l_mem[l_raddr];
		end
	end

	`TRR_ASSERT(a_cnt_bound, (h_cnt_q <= DEPTH_C) && (l_cnt_q <= DEPTH_C), "queue count beyond depth")
	`TRR_ASSERT_IMP(a_append_room, uw.uop == U_APPEND, !flags.dst_full, "append into a full queue")
	`TRR_ASSERT_IMP(a_remove_nonempty, (uw.uop == U_POPMV) || (uw.uop == U_DROP), !flags.src_empty, "removal from an empty queue")
	`TRR_ASSERT_NXT(a_expiry_clears, (uw.uop == U_TICK) && !flags.no_rot, elapsed_q == '0, "expiry left elapsed count set")

endmodule

@@ tb/sv/two_level_round_robin_scheduler_test.sv @@
`timescale 1ns / 1ps

module two_level_round_robin_scheduler_test;
	import trr_pkg::*;

	localparam int QDEPTH      = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 240;
	localparam int HOLD_AFTER  = 620;
	localparam int HOLD_CYCLES = 400;

	// cumulative command mix per mode: fill, drain, mixed
	localparam cmd_t MIX_CMDS [7] = '{CMD_ADD, CMD_FINISH, CMD_PROMOTE_HEAD, CMD_PROMOTE_ID,
		CMD_DEMOTE_HEAD, CMD_DEMOTE_ID, CMD_TICK};
	localparam int MIX_CUM [3][7] = '{
		'{40, 45, 60, 70, 75, 80, 100},
		'{10, 35, 44, 53, 68, 80, 100},
		'{20, 32, 44, 56, 68, 80, 100}
	};

	typedef struct {
		cmd_t              op;
		logic [TASK_W-1:0] id;
		int                reps;
		bit                typed;
		result_t           want;
	} plan_row_t;

	typedef struct {
		bit      typed;
		result_t want;
	} typed_run_t;

	logic clk;
	logic arst_n;

	trr_cmd_if cmd_ch ();
	trr_res_if res_ch ();
	trr_cfg_if cfg_ch ();

	two_level_round_robin_scheduler uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// scheduler state as predicted
	logic [TASK_W-1:0]  hi_tasks [$];
	logic [TASK_W-1:0]  lo_tasks [$];
	logic [QUANT_W-1:0] quantum = QUANTUM_RESET;
	logic [QUANT_W-1:0] elapsed = '0;

	result_t    expected_runs [$];
	typed_run_t typed_runs [$];
	plan_row_t  plan [$];

	int  commands_sent = 0;
	int  results_seen  = 0;
	int  mismatches    = 0;
	int  cycles        = 0;
	bit  calm          = 1'b0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic status_t move_task(bit up, bit by_id, logic [TASK_W-1:0] id);
		int pos;
		int n_src;
		int n_dst;
		n_src = up ? lo_tasks.size() : hi_tasks.size();
		n_dst = up ? hi_tasks.size() : lo_tasks.size();
		pos = 0;
		if (by_id) begin
			while (pos < n_src && (up ? lo_tasks[pos] : hi_tasks[pos]) != id)
				pos++;
			if (pos >= n_src)
				return ST_NOT_FOUND;
		end else if (n_src == 0) begin
			return ST_EMPTY;
		end
		if (n_dst >= QDEPTH)
			return ST_FULL;
		if (up) begin
			hi_tasks.push_back(lo_tasks[pos]);
			lo_tasks.delete(pos);
		end else begin
			lo_tasks.push_back(hi_tasks[pos]);
			hi_tasks.delete(pos);
		end
		return ST_OK;
	endfunction

	function automatic result_t schedule_step(cmd_t op, logic [TASK_W-1:0] id);
		status_t            st;
		bit                 on_high;
		logic [QUANT_W-1:0] q;
		result_t            r;
		st = ST_OK;
		on_high = hi_tasks.size() > 0;
		if (op != CMD_TICK && op <= CMD_DEMOTE_ID)
			elapsed = '0;
		case (op)
			CMD_TICK: begin
				if (hi_tasks.size() + lo_tasks.size() > 0) begin
					q = (quantum == '0) ? QUANT_W'(1) : quantum;
					if (elapsed != '1)
						elapsed++;
					if (elapsed >= q) begin
						if (on_high)
							hi_tasks.push_back(hi_tasks.pop_front());
						else
							lo_tasks.push_back(lo_tasks.pop_front());
						elapsed = '0;
					end
				end else begin
					elapsed = '0;
				end
			end
			CMD_ADD: begin
				if (lo_tasks.size() >= QDEPTH)
					st = ST_FULL;
				else
					lo_tasks.push_back(id);
			end
			CMD_FINISH: begin
				if (on_high)
					void'(hi_tasks.pop_front());
				else if (lo_tasks.size() > 0)
					void'(lo_tasks.pop_front());
				else
					st = ST_NO_FINISH;
			end
			CMD_PROMOTE_HEAD: st = move_task(1'b1, 1'b0, id);
			CMD_PROMOTE_ID:   st = move_task(1'b1, 1'b1, id);
			CMD_DEMOTE_HEAD:  st = move_task(1'b0, 1'b0, id);
			CMD_DEMOTE_ID:    st = move_task(1'b0, 1'b1, id);
			default: ;
		endcase
		if (hi_tasks.size() > 0)
			r = '{hi_tasks[0], 1'b1, 1'b1, st};
		else if (lo_tasks.size() > 0)
			r = '{lo_tasks[0], 1'b1, 1'b0, st};
		else
			r = '{{TASK_W{1'b0}}, 1'b0, 1'b0, st};
		return r;
	endfunction

	function automatic void flag_bad(string what, result_t want, result_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected id=%h valid=%b high=%b status=%0d, got id=%h valid=%b high=%b status=%0d",
				$time, what, want.running_id, want.running_valid, want.running_is_high,
				want.status, got.running_id, got.running_valid, got.running_is_high, got.status);
	endfunction

	always @(posedge clk) begin : monitor
		result_t    want;
		result_t    got;
		typed_run_t meta;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				quantum = cfg_ch.quantum_ticks;
			if (cmd_ch.valid && cmd_ch.ready) begin
				want = schedule_step(cmd_t'(cmd_ch.command), cmd_ch.task_id);
				meta = typed_runs.pop_front();
				if (meta.typed)
					want = meta.want;
				expected_runs.push_back(want);
			end
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				got = '{res_ch.running_id, res_ch.running_valid, res_ch.running_is_high,
					status_t'(res_ch.status)};
				if (expected_runs.size() == 0) begin
					flag_bad("unexpected result", '0, got);
				end else begin
					want = expected_runs.pop_front();
					if (got !== want)
						flag_bad("result mismatch", want, got);
				end
			end
		end
	end

	// mostly no gap, else mostly short gaps and a few long ones; none while calm
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin : res_ready_ctl
		int  len;
		bit  held;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		res_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				// long stall so the block backs up and stops taking commands
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else begin
				len = idle_gap();
				if (len > 0) begin
					res_ch.ready <= 1'b0;
					repeat (len) @(posedge clk);
					res_ch.ready <= 1'b1;
				end
			end
		end
	end

	task automatic send_cmd(cmd_t op, logic [TASK_W-1:0] id, bit typed, result_t want);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= op;
		cmd_ch.task_id <= id;
		typed_runs.push_back('{typed, want});
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		commands_sent++;
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (results_seen < commands_sent);
	endtask

	task automatic write_quantum(logic [QUANT_W-1:0] value);
		cfg_ch.valid         <= 1'b1;
		cfg_ch.quantum_ticks <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic cmd_t pick_cmd(int mode);
		int r;
		r = $urandom_range(0, 99);
		for (int k = 0; k < 7; k++)
			if (r < MIX_CUM[mode][k])
				return MIX_CMDS[k];
		return CMD_TICK;
	endfunction

	// by-id moves mostly name a queued task; adds reuse a small pool for duplicates
	function automatic logic [TASK_W-1:0] pick_id(cmd_t op);
		int                r;
		logic [TASK_W-1:0] v;
		r = $urandom_range(0, 99);
		v = TASK_W'($urandom);
		if (op == CMD_PROMOTE_ID && lo_tasks.size() > 0 && r < 60)
			return lo_tasks[$urandom_range(0, lo_tasks.size() - 1)];
		if (op == CMD_DEMOTE_ID && hi_tasks.size() > 0 && r < 60)
			return hi_tasks[$urandom_range(0, hi_tasks.size() - 1)];
		if (r < 75)
			return {{(TASK_W-3){1'b0}}, v[2:0]};
		if (r < 85)
			return v[0] ? {TASK_W{1'b1}} : {TASK_W{1'b0}};
		return v;
	endfunction

	task automatic run_random(int n);
		int   left_in_mode;
		int   mode;
		cmd_t op;
		left_in_mode = 0;
		mode = 0;
		repeat (n) begin
			if (left_in_mode == 0) begin
				mode = $urandom_range(0, 2);
				left_in_mode = $urandom_range(15, 60);
				calm = ($urandom_range(0, 4) == 0);
			end
			left_in_mode--;
			op = pick_cmd(mode);
			send_cmd(op, pick_id(op), 1'b0, '0);
		end
		calm = 1'b0;
	endtask

	function automatic plan_row_t plan_row(cmd_t op, logic [TASK_W-1:0] id, int reps, bit typed,
		logic [TASK_W-1:0] rid, bit rv, bit rh, status_t st);
		plan_row_t p;
		p.op    = op;
		p.id    = id;
		p.reps  = reps;
		p.typed = typed;
		p.want  = '{rid, rv, rh, st};
		return p;
	endfunction

	initial begin : stimulus
		logic [QUANT_W-1:0] quanta [6];
		quanta = '{16'd1, 16'hFFFF, 16'd2, 16'd3, 16'd7, 16'd4};

		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_TICK;
		cmd_ch.task_id <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.quantum_ticks <= QUANTUM_RESET;

		// empty scheduler, then two tasks through a full quantum at the reset value
		plan.push_back(plan_row(CMD_TICK,         16'h0000, 1, 1'b1, 16'h0000, 1'b0, 1'b0,
			ST_OK));
		plan.push_back(plan_row(CMD_FINISH,       16'h0000, 1, 1'b1, 16'h0000, 1'b0, 1'b0,
			ST_NO_FINISH));
		plan.push_back(plan_row(CMD_PROMOTE_HEAD, 16'h0000, 1, 1'b1, 16'h0000, 1'b0, 1'b0,
			ST_EMPTY));
		plan.push_back(plan_row(CMD_DEMOTE_HEAD,  16'hFFFF, 1, 1'b1, 16'h0000, 1'b0, 1'b0,
			ST_EMPTY));
		plan.push_back(plan_row(CMD_PROMOTE_ID,   16'h0005, 1, 1'b1, 16'h0000, 1'b0, 1'b0,
			ST_NOT_FOUND));
		plan.push_back(plan_row(CMD_DEMOTE_ID,    16'h0005, 1, 1'b1, 16'h0000, 1'b0, 1'b0,
			ST_NOT_FOUND));
		plan.push_back(plan_row(CMD_ADD,          16'hFFFF, 1, 1'b1, 16'hFFFF, 1'b1, 1'b0,
			ST_OK));
		plan.push_back(plan_row(CMD_ADD,          16'h0000, 1, 1'b1, 16'hFFFF, 1'b1, 1'b0,
			ST_OK));
		plan.push_back(plan_row(CMD_TICK,         16'h0000, 9, 1'b1, 16'hFFFF, 1'b1, 1'b0,
			ST_OK));
		plan.push_back(plan_row(CMD_TICK,         16'h0000, 1, 1'b1, 16'h0000, 1'b1, 1'b0,
			ST_OK));
		// duplicate id: by-id move takes the one nearest the head
		plan.push_back(plan_row(CMD_ADD,          16'h0000, 1, 1'b0, '0, 1'b0, 1'b0, ST_OK));
		plan.push_back(plan_row(CMD_PROMOTE_ID,   16'h0000, 1, 1'b0, '0, 1'b0, 1'b0, ST_OK));
		plan.push_back(plan_row(CMD_PROMOTE_HEAD, 16'h1234, 1, 1'b0, '0, 1'b0, 1'b0, ST_OK));
		plan.push_back(plan_row(CMD_DEMOTE_ID,    16'hFFFF, 1, 1'b0, '0, 1'b0, 1'b0, ST_OK));
		plan.push_back(plan_row(CMD_DEMOTE_HEAD,  16'h0000, 1, 1'b0, '0, 1'b0, 1'b0, ST_OK));
		plan.push_back(plan_row(CMD_PROMOTE_ID,   16'h1234, 1, 1'b0, '0, 1'b0, 1'b0, ST_OK));
		plan.push_back(plan_row(CMD_ADD,          16'h8000, 1, 1'b0, '0, 1'b0, 1'b0, ST_OK));
		plan.push_back(plan_row(CMD_ADD,          16'h7FFF, 1, 1'b0, '0, 1'b0, 1'b0, ST_OK));
		plan.push_back(plan_row(CMD_FINISH,       16'h0000, 3, 1'b0, '0, 1'b0, 1'b0, ST_OK));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			repeat (plan[i].reps)
				send_cmd(plan[i].op, plan[i].id, plan[i].typed, plan[i].want);
		run_random(PHASE_ITEMS);

		foreach (quanta[i]) begin
			wait_drained();
			write_quantum(quanta[i]);
			run_random(PHASE_ITEMS);
		end

		wait_drained();
		repeat (80) @(posedge clk);
		if (mismatches == 0 && expected_runs.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/trr_pkg.sv
hdl/trr_ifs.sv
hdl/trr_seq.sv
hdl/trr_dp.sv
hdl/two_level_round_robin_scheduler.sv
tb/sv/two_level_round_robin_scheduler_test.sv
